// File: sv/poly1305_mac_unit_macros.svh
// assertion macros used by the poly1305 mac checker
`ifndef POLY1305_MAC_UNIT_MACROS_SVH
`define POLY1305_MAC_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define P1305_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define P1305_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/p1305_pkg.sv
// shared types, constants and command codes of the poly1305 mac
package p1305_pkg;

    // config port
    localparam int CFG_INDEX_W_DEF = 8;
    localparam logic [1:0] REG_R_KEY_LOW    = 2'd0;
    localparam logic [1:0] REG_R_KEY_HIGH   = 2'd1;
    localparam logic [1:0] REG_PAD_KEY_LOW  = 2'd2;
    localparam logic [1:0] REG_PAD_KEY_HIGH = 2'd3;

    // stream widths
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 128;

    // limb masks and key clamps
    localparam logic [63:0] MASK44  = 64'h0000_0fff_ffff_ffff;
    localparam logic [63:0] MASK42  = 64'h0000_03ff_ffff_ffff;
    localparam logic [63:0] CLAMP0  = 64'h0000_0ffc_0fff_ffff;
    localparam logic [63:0] CLAMP1  = 64'h0000_0fff_ffc0_ffff;
    localparam logic [63:0] CLAMP2  = 64'h0000_000f_ffff_fc0f;
    localparam logic [63:0] TOP_BIT = 64'h0000_0100_0000_0000;
    localparam logic [63:0] FIN_SUB = 64'h0000_0400_0000_0000;

    // multiply schedule: three sums of three limb products, four quarters each
    localparam int MUL_TERMS = 3;
    localparam int MUL_PARTS = 4;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE   = 5'd0;
    localparam op_t OP_ABSORB = 5'd1;
    localparam op_t OP_MUL    = 5'd2;
    localparam op_t OP_RED0   = 5'd3;
    localparam op_t OP_RED1   = 5'd4;
    localparam op_t OP_RED2   = 5'd5;
    localparam op_t OP_RED3   = 5'd6;
    localparam op_t OP_FIN0   = 5'd7;
    localparam op_t OP_FIN1   = 5'd8;
    localparam op_t OP_FIN2   = 5'd9;
    localparam op_t OP_FIN3   = 5'd10;
    localparam op_t OP_FIN4   = 5'd11;
    localparam op_t OP_FIN5   = 5'd12;
    localparam op_t OP_FIN6   = 5'd13;
    localparam op_t OP_FIN7   = 5'd14;
    localparam op_t OP_FIN8   = 5'd15;
    localparam op_t OP_EMIT   = 5'd16;

    typedef struct packed {
        op_t        op;
        logic [1:0] dsel;   // which product sum
        logic [1:0] hsel;   // which accumulator limb
        logic [1:0] part;   // quarter: bit 1 picks limb half, bit 0 key half
    } cmd_t;

    typedef struct packed {
        logic blk_empty;
        logic blk_last;
        logic out_busy;
    } status_t;

endpackage

// File: sv/p1305_ctrl.sv
// sequencer of the poly1305 mac: absorb, multiply, reduce, finish
module p1305_ctrl
    import p1305_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t sts,
    output cmd_t    cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_ABSORB = 5'd1;
    localparam logic [4:0] ST_MUL    = 5'd2;
    localparam logic [4:0] ST_DRAIN  = 5'd3;
    localparam logic [4:0] ST_RED0   = 5'd4;
    localparam logic [4:0] ST_RED1   = 5'd5;
    localparam logic [4:0] ST_RED2   = 5'd6;
    localparam logic [4:0] ST_RED3   = 5'd7;
    localparam logic [4:0] ST_FIN0   = 5'd8;
    localparam logic [4:0] ST_FIN1   = 5'd9;
    localparam logic [4:0] ST_FIN2   = 5'd10;
    localparam logic [4:0] ST_FIN3   = 5'd11;
    localparam logic [4:0] ST_FIN4   = 5'd12;
    localparam logic [4:0] ST_FIN5   = 5'd13;
    localparam logic [4:0] ST_FIN6   = 5'd14;
    localparam logic [4:0] ST_FIN7   = 5'd15;
    localparam logic [4:0] ST_FIN8   = 5'd16;
    localparam logic [4:0] ST_EMIT   = 5'd17;

    localparam logic [1:0] LAST_PART = 2'(MUL_PARTS - 1);
    localparam logic [1:0] LAST_TERM = 2'(MUL_TERMS - 1);

    logic [4:0] state_reg, state_next;
    logic [1:0] dsel_reg, dsel_next;
    logic [1:0] hsel_reg, hsel_next;
    logic [1:0] part_reg, part_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dsel_reg  <= '0;
            hsel_reg  <= '0;
            part_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dsel_reg  <= dsel_next;
            hsel_reg  <= hsel_next;
            part_reg  <= part_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dsel_next  = dsel_reg;
        hsel_next  = hsel_reg;
        part_next  = part_reg;
        cmd.op     = OP_NONE;
        cmd.dsel   = dsel_reg;
        cmd.hsel   = hsel_reg;
        cmd.part   = part_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB:
            begin
                cmd.op    = OP_ABSORB;
                dsel_next = '0;
                hsel_next = '0;
                part_next = '0;
                if (!sts.blk_empty)
                begin
                    state_next = ST_MUL;
                end
                else if (sts.blk_last)
                begin
                    state_next = ST_FIN0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                cmd.op    = OP_MUL;
                part_next = part_reg + 2'd1;
                if (part_reg == LAST_PART)
                begin
                    part_next = '0;
                    hsel_next = hsel_reg + 2'd1;
                    if (hsel_reg == LAST_TERM)
                    begin
                        hsel_next = '0;
                        dsel_next = dsel_reg + 2'd1;
                        if (dsel_reg == LAST_TERM)
                        begin
                            dsel_next  = '0;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            // last product still in flight
            ST_DRAIN: state_next = ST_RED0;
            ST_RED0:
            begin
                cmd.op     = OP_RED0;
                state_next = ST_RED1;
            end
            ST_RED1:
            begin
                cmd.op     = OP_RED1;
                state_next = ST_RED2;
            end
            ST_RED2:
            begin
                cmd.op     = OP_RED2;
                state_next = ST_RED3;
            end
            ST_RED3:
            begin
                cmd.op     = OP_RED3;
                state_next = sts.blk_last ? ST_FIN0 : ST_IDLE;
            end
            ST_FIN0:
            begin
                cmd.op     = OP_FIN0;
                state_next = ST_FIN1;
            end
            ST_FIN1:
            begin
                cmd.op     = OP_FIN1;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.op     = OP_FIN2;
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                cmd.op     = OP_FIN3;
                state_next = ST_FIN4;
            end
            ST_FIN4:
            begin
                cmd.op     = OP_FIN4;
                state_next = ST_FIN5;
            end
            ST_FIN5:
            begin
                cmd.op     = OP_FIN5;
                state_next = ST_FIN6;
            end
            ST_FIN6:
            begin
                cmd.op     = OP_FIN6;
                state_next = ST_FIN7;
            end
            ST_FIN7:
            begin
                cmd.op     = OP_FIN7;
                state_next = ST_FIN8;
            end
            ST_FIN8:
            begin
                cmd.op     = OP_FIN8;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // wait for room in the output register
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// File: sv/p1305_dp.sv
// datapath of the poly1305 mac: key registers, accumulator, limb multiplier, tag register
module p1305_dp
    import p1305_pkg::*;
#(
    parameter int CFG_INDEX_W = CFG_INDEX_W_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_beat,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    input  cmd_t                   cmd,
    output status_t                sts,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [63:0]  rkey_lo_reg, rkey_hi_reg, pad_lo_reg, pad_hi_reg;
    logic [63:0]  blk_lo_reg, blk_hi_reg;
    logic [4:0]   cnt_reg;
    logic         last_reg;
    logic [63:0]  h0_reg, h1_reg, h2_reg, h0_next, h1_next, h2_next;
    logic [127:0] d0_reg, d1_reg, d2_reg, d0_next, d1_next, d2_next;
    logic [63:0]  prod_reg;
    logic [1:0]   prod_dsel_reg, prod_shift_reg;
    logic         prod_vld_reg;
    logic [127:0] tag_reg, tag_next;
    logic         out_vld_reg, out_vld_next;

    logic [63:0]  r0, r1, r2, s1, s2;
    logic [63:0]  a_limb, b_coef;
    logic [31:0]  a_piece, b_piece;
    logic [63:0]  prod_full;
    logic [127:0] addend;
    logic [63:0]  pad_lo, pad_hi, top, pmask;
    logic [5:0]   sh;
    logic [63:0]  c2, gsum, psum, cr;

    // clamped r and the 5*4 multiples for the wrapped limbs
    assign r0 = rkey_lo_reg & CLAMP0;
    assign r1 = ((rkey_lo_reg >> 44) | (rkey_hi_reg << 20)) & CLAMP1;
    assign r2 = (rkey_hi_reg >> 24) & CLAMP2;
    assign s1 = (r1 << 4) + (r1 << 2);
    assign s2 = (r2 << 4) + (r2 << 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rkey_lo_reg <= '0;
            rkey_hi_reg <= '0;
            pad_lo_reg  <= '0;
            pad_hi_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_INDEX_W'(REG_R_KEY_LOW))
            begin
                rkey_lo_reg <= cfg_data;
            end
            if (cfg_index == CFG_INDEX_W'(REG_R_KEY_HIGH))
            begin
                rkey_hi_reg <= cfg_data;
            end
            if (cfg_index == CFG_INDEX_W'(REG_PAD_KEY_LOW))
            begin
                pad_lo_reg <= cfg_data;
            end
            if (cfg_index == CFG_INDEX_W'(REG_PAD_KEY_HIGH))
            begin
                pad_hi_reg <= cfg_data;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            blk_lo_reg <= s_tdata[63:0];
            blk_hi_reg <= s_tdata[127:64];
            cnt_reg    <= s_tdata[132:128];
            last_reg   <= s_tlast;
        end
    end

    assign sts.blk_empty = (cnt_reg == 5'd0);
    assign sts.blk_last  = last_reg;
    assign sts.out_busy  = out_vld_reg & ~m_tready;

    // operand select for one 32x32 partial product
    always_comb
    begin
        case (cmd.hsel)
            2'd0:    a_limb = h0_reg;
            2'd1:    a_limb = h1_reg;
            default: a_limb = h2_reg;
        endcase
        case ({cmd.dsel, cmd.hsel})
            4'b00_00: b_coef = r0;
            4'b00_01: b_coef = s2;
            4'b00_10: b_coef = s1;
            4'b01_00: b_coef = r1;
            4'b01_01: b_coef = r0;
            4'b01_10: b_coef = s2;
            4'b10_00: b_coef = r2;
            4'b10_01: b_coef = r1;
            4'b10_10: b_coef = r0;
            default:  b_coef = '0;
        endcase
        a_piece = cmd.part[1] ? a_limb[63:32] : a_limb[31:0];
        b_piece = cmd.part[0] ? b_coef[63:32] : b_coef[31:0];
    end

    assign prod_full = a_piece * b_piece;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= (cmd.op == OP_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_full;
        prod_dsel_reg  <= cmd.dsel;
        prod_shift_reg <= 2'({1'b0, cmd.part[1]} + {1'b0, cmd.part[0]});
    end

    assign addend = {64'd0, prod_reg} << {prod_shift_reg, 5'd0};

    // block padding
    always_comb
    begin
        sh     = {cnt_reg[2:0], 3'b000};
        pmask  = (64'd1 << sh) - 64'd1;
        pad_lo = blk_lo_reg;
        pad_hi = blk_hi_reg;
        top    = '0;
        if (cnt_reg >= 5'd16)
        begin
            top = TOP_BIT;
        end
        else if (cnt_reg[4:3] == 2'b00)
        begin
            pad_lo = (blk_lo_reg & pmask) | (64'd1 << sh);
            pad_hi = '0;
        end
        else
        begin
            pad_hi = (blk_hi_reg & pmask) | (64'd1 << sh);
        end
    end

    always_comb
    begin
        h0_next      = h0_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        d0_next      = d0_reg;
        d1_next      = d1_reg;
        d2_next      = d2_reg;
        tag_next     = tag_reg;
        out_vld_next = out_vld_reg & ~m_tready;
        c2           = h2_reg >> 42;
        gsum         = h0_reg + 64'd5;
        psum         = h0_reg + (pad_lo_reg & MASK44);
        cr           = d0_reg[63:0];

        if (prod_vld_reg)
        begin
            case (prod_dsel_reg)
                2'd0:    d0_next = d0_reg + addend;
                2'd1:    d1_next = d1_reg + addend;
                default: d2_next = d2_reg + addend;
            endcase
        end

        case (cmd.op)
            OP_ABSORB:
            begin
                if (cnt_reg != 5'd0)
                begin
                    h0_next = h0_reg + (pad_lo & MASK44);
                    h1_next = h1_reg + (((pad_lo >> 44) | (pad_hi << 20)) & MASK44);
                    h2_next = h2_reg + ((pad_hi >> 24) | top);
                end
                d0_next = '0;
                d1_next = '0;
                d2_next = '0;
            end
            OP_RED0:
            begin
                h0_next = d0_reg[63:0] & MASK44;
                d1_next = d1_reg + {64'd0, d0_reg[107:44]};
            end
            OP_RED1:
            begin
                h1_next = d1_reg[63:0] & MASK44;
                d2_next = d2_reg + {64'd0, d1_reg[107:44]};
            end
            OP_RED2:
            begin
                // top carry parked in d0 for the times-five fold
                h2_next = d2_reg[63:0] & MASK42;
                d0_next = {64'd0, d2_reg[105:42]};
            end
            OP_RED3: h0_next = h0_reg + (cr << 2) + cr;
            OP_FIN0, OP_FIN3:
            begin
                h1_next = h1_reg + (h0_reg >> 44);
                h0_next = h0_reg & MASK44;
            end
            OP_FIN1:
            begin
                h2_next = h2_reg + (h1_reg >> 44);
                h1_next = h1_reg & MASK44;
            end
            OP_FIN2:
            begin
                h0_next = h0_reg + (c2 << 2) + c2;
                h2_next = h2_reg & MASK42;
            end
            // g = h + 5 - 2^130, built in the low halves of d
            OP_FIN4:
            begin
                d0_next = {64'd0, gsum & MASK44};
                d1_next = {64'd0, h1_reg + (gsum >> 44)};
            end
            OP_FIN5:
            begin
                d1_next = {64'd0, d1_reg[63:0] & MASK44};
                d2_next = {64'd0, h2_reg + (d1_reg[63:0] >> 44) - FIN_SUB};
            end
            OP_FIN6:
            begin
                if (!d2_reg[63])
                begin
                    h0_next = d0_reg[63:0];
                    h1_next = d1_reg[63:0];
                    h2_next = d2_reg[63:0];
                end
            end
            OP_FIN7:
            begin
                h0_next = psum & MASK44;
                h1_next = h1_reg + (((pad_lo_reg >> 44) | (pad_hi_reg << 20)) & MASK44)
                          + (psum >> 44);
            end
            OP_FIN8:
            begin
                h1_next = h1_reg & MASK44;
                h2_next = h2_reg + (pad_hi_reg >> 24) + (h1_reg >> 44);
            end
            OP_EMIT:
            begin
                tag_next     = {(h1_reg >> 20) | (h2_reg << 24), h0_reg | (h1_reg << 44)};
                out_vld_next = 1'b1;
                h0_next      = '0;
                h1_next      = '0;
                h2_next      = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h0_reg      <= '0;
            h1_reg      <= '0;
            h2_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            h0_reg      <= h0_next;
            h1_reg      <= h1_next;
            h2_reg      <= h2_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg  <= d0_next;
        d1_reg  <= d1_next;
        d2_reg  <= d2_next;
        tag_reg <= tag_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = tag_reg;

endmodule

// File: sv/poly1305_mac_unit.sv
// top level of the poly1305 one-time authenticator
//
// Poly1305 tag engine. Write the 32-byte one-time key through the config
// port (index 0/1: r key words, clamped inside; index 2/3: s words), then
// stream the message one 16-byte block per beat; the beat with tlast set
// yields one 128-bit tag beat. A data block (byte count 1..31, counts past
// 16 act as 16) is worked on from its beat to the next accepted beat in
// order: an absorb step, the nine limb products of h*r mod 2^130-5 worked
// through a quarter at a time by a single 32x32 multiplier, a drain step,
// the carry steps and the idle state that takes the next beat. The last
// beat adds final reduction, s addition and tag load, plus any wait for
// the previous tag to be taken. A beat with byte count 0 adds nothing and
// skips the multiply, going straight to the finish with tlast. The tag
// register frees the core from the consumer: the next message may start
// while a tag still waits. Key words are read while a block is worked on,
// so write them only between beats with no work pending.
module poly1305_mac_unit
    import p1305_pkg::*;
#(
    parameter int CFG_INDEX_W = CFG_INDEX_W_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // message beats
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // block_low[63:0], block_high[127:64],
                                              // byte_count[132:128], zero pad
    input  logic                   s_tlast,   // last
    // tag beats
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // tag_low[63:0], tag_high[127:64]
    // key register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    cmd_t    cmd;
    status_t sts;
    logic    in_beat;

    // key writes are always taken
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid & s_tready;

    p1305_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    p1305_dp
    #(
        .CFG_INDEX_W (CFG_INDEX_W)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// File: sv/p1305_checker.sv
// port-level checks of the poly1305 mac, bound to the top level
`include "poly1305_mac_unit_macros.svh"

module p1305_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // a stalled tag holds
    `P1305_ASSERT_NEXT(a_tag_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "tag changed while stalled")

    // one block in work at a time
    `P1305_ASSERT_NEXT(a_one_block, clk, rst_n, s_tvalid && s_tready, !s_tready, "input ready right after a beat")

    // a tag only comes out of the finish sequence, never from idle
    `P1305_ASSERT_IMPL(a_tag_origin, clk, rst_n, $rose(m_tvalid), !$past(s_tready), "tag appeared while idle")

endmodule

bind poly1305_mac_unit p1305_checker u_checker (.*);
